// ----- hdl/stlr_pkg.sv -----
// Package for the styled thick line rasterizer: coordinate and counter widths,
// register indexes, style and operation codes, and register reset values.
// No dependencies; imported by the core and its checker.
`timescale 1ns / 1ps
`default_nettype none

package stlr_pkg;

    // coordinate and decision term widths
    localparam int COORD_BITS = 12;
    localparam int DEC_BITS   = COORD_BITS + 2;
    localparam int MAX_WIDTH  = 16;
    localparam int WIDX_BITS  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

    // stream payload widths
    localparam int IN_DATA_BITS  = 4 * COORD_BITS;
    localparam int IN_TDATA_W    = ((IN_DATA_BITS + 7) / 8) * 8;
    localparam int OUT_DATA_BITS = 2 * COORD_BITS;
    localparam int OUT_TDATA_W   = ((OUT_DATA_BITS + 7) / 8) * 8;

    // register field widths
    localparam int LW_BITS    = 5;
    localparam int STYLE_BITS = 2;
    localparam int CNT_BITS   = 6;
    localparam int DASH_BITS  = 7;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 6;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_LINE_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LINE_STYLE  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DOT_PERIOD  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DASH_LENGTH = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_GAP_LENGTH  = 3'd4;

    // line styles
    localparam logic [STYLE_BITS-1:0] STYLE_SOLID  = 2'd0;
    localparam logic [STYLE_BITS-1:0] STYLE_DOTTED = 2'd1;
    localparam logic [STYLE_BITS-1:0] STYLE_DASHED = 2'd2;

    // input operations
    localparam logic OP_LOAD    = 1'b0;
    localparam logic OP_ADVANCE = 1'b1;

    // register reset values
    localparam logic [LW_BITS-1:0]    RST_LINE_WIDTH  = 5'd1;
    localparam logic [STYLE_BITS-1:0] RST_LINE_STYLE  = STYLE_SOLID;
    localparam logic [CNT_BITS-1:0]   RST_DOT_PERIOD  = 6'd10;
    localparam logic [CNT_BITS-1:0]   RST_DASH_LENGTH = 6'd10;
    localparam logic [CNT_BITS-1:0]   RST_GAP_LENGTH  = 6'd15;

    // output tuser bit positions
    localparam int USER_PLOT = 0;
    localparam int USER_IDLE = 1;

endpackage

`default_nettype wire

// ----- hdl/styled_thick_line_rasterizer_core.sv -----
// Styled thick line rasterizer core: Bresenham walk with width, dot and dash
// patterns, one pixel word per advance command.
// Depends on stlr_pkg.
//
// Usage:
//   s_axis carries commands. tuser is the operation: load latches the two
//   endpoints in tdata and starts a new line (no output word); advance emits
//   one pixel word on m_axis. An advance with no line active emits an idle
//   word (tuser idle bit set, everything else zero).
//   m_axis tdata is the pixel position, tuser holds plot and idle, tlast
//   marks the final pixel of the line.
//   cfg_we/cfg_index/cfg_data write the style registers; write them only
//   while no command is in flight.
// Timing:
//   An advance's output word becomes valid in the cycle after the command is accepted.
//   Throughput is one command per cycle while the output is not stalled: the walk
//   state (position, decision term, counters) updates by one adder step per accepted
//   advance, and the output register is refilled in the same cycle it is drained.
//   A solid or dashed step of width w takes w advance commands.
// Reset and stall:
//   rst_n clears the walk state and output valid, and restores the register
//   defaults. When a valid output word is not taken (m_axis_tready low) it holds and
//   s_axis_tready drops, so no command is taken until the word is consumed.
`timescale 1ns / 1ps
`default_nettype none

module styled_thick_line_rasterizer_core
    import stlr_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    // command stream
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    // tdata: start_x, start_y, end_x, end_y
    input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // tuser: op
    input  wire logic                   s_axis_tuser,
    // pixel stream
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    // tdata: pixel_x, pixel_y
    output logic [OUT_TDATA_W-1:0]      m_axis_tdata,
    // tuser: plot, idle
    output logic [1:0]                  m_axis_tuser,
    // tlast: last
    output logic                        m_axis_tlast,
    // register write port
    input  wire logic                   cfg_we,
    input  wire logic [CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

    // configuration registers
    logic [LW_BITS-1:0]    line_width_reg;
    logic [STYLE_BITS-1:0] line_style_reg;
    logic [CNT_BITS-1:0]   dot_period_reg;
    logic [CNT_BITS-1:0]   dash_length_reg;
    logic [CNT_BITS-1:0]   gap_length_reg;

    // walk state
    logic                         active_reg, active_next;
    logic [COORD_BITS-1:0]        cur_x_reg, cur_x_next;
    logic [COORD_BITS-1:0]        cur_y_reg, cur_y_next;
    logic [COORD_BITS-1:0]        major_reg, major_next;
    logic [COORD_BITS-1:0]        minor_reg, minor_next;
    logic signed [DEC_BITS-1:0]   decision_reg, decision_next;
    logic [COORD_BITS-1:0]        steps_left_reg, steps_left_next;
    logic                         neg_x_reg, neg_x_next;
    logic                         neg_y_reg, neg_y_next;
    logic                         flip_reg, flip_next;
    logic [WIDX_BITS-1:0]         width_index_reg, width_index_next;
    logic [CNT_BITS-1:0]          dot_counter_reg, dot_counter_next;
    logic [DASH_BITS-1:0]         dash_counter_reg, dash_counter_next;
    logic                         in_gap_reg, in_gap_next;
    logic [CNT_BITS-1:0]          gap_counter_reg, gap_counter_next;

    // output register
    logic                         out_valid_reg, out_valid_next;
    logic [COORD_BITS-1:0]        out_x_reg, out_x_next;
    logic [COORD_BITS-1:0]        out_y_reg, out_y_next;
    logic                         out_plot_reg, out_plot_next;
    logic                         out_last_reg, out_last_next;
    logic                         out_idle_reg, out_idle_next;

    logic in_accept;

    // endpoint fields
    logic signed [COORD_BITS-1:0] start_x, start_y, end_x, end_y;
    logic signed [COORD_BITS:0]   diff_x, diff_y;
    logic [COORD_BITS-1:0]        abs_x, abs_y;
    logic                         load_flip;
    logic [COORD_BITS-1:0]        load_major, load_minor;
    logic signed [DEC_BITS-1:0]   load_decision;

    // per-pixel pattern logic
    logic [7:0]                   width_eff;
    logic                         width_done;
    logic [WIDX_BITS-1:0]         offset;
    logic                         plot;
    logic                         step_done;
    logic [DASH_BITS-1:0]         dash_mid;
    logic [CNT_BITS-1:0]          gap_mid;
    logic                         in_gap_mid;
    logic [DASH_BITS-1:0]         dash_eff;
    logic [CNT_BITS-1:0]          gap_eff;
    logic [CNT_BITS-1:0]          dot_eff;
    logic [CNT_BITS:0]            dot_inc;
    logic [COORD_BITS-1:0]        pix_x, pix_y;
    logic [COORD_BITS-1:0]        x_stepped, y_stepped;
    logic signed [DEC_BITS-1:0]   two_minor, two_major;

    // handshake
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = !out_valid_reg || m_axis_tready;

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_width_reg  <= RST_LINE_WIDTH;
            line_style_reg  <= RST_LINE_STYLE;
            dot_period_reg  <= RST_DOT_PERIOD;
            dash_length_reg <= RST_DASH_LENGTH;
            gap_length_reg  <= RST_GAP_LENGTH;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_LINE_WIDTH:  line_width_reg  <= cfg_data[LW_BITS-1:0];
                REG_LINE_STYLE:  line_style_reg  <= cfg_data[STYLE_BITS-1:0];
                REG_DOT_PERIOD:  dot_period_reg  <= cfg_data[CNT_BITS-1:0];
                REG_DASH_LENGTH: dash_length_reg <= cfg_data[CNT_BITS-1:0];
                REG_GAP_LENGTH:  gap_length_reg  <= cfg_data[CNT_BITS-1:0];
                default:         ;
            endcase
        end
    end

    // line setup from endpoints
    assign start_x = s_axis_tdata[COORD_BITS-1:0];
    assign start_y = s_axis_tdata[2*COORD_BITS-1:COORD_BITS];
    assign end_x   = s_axis_tdata[3*COORD_BITS-1:2*COORD_BITS];
    assign end_y   = s_axis_tdata[4*COORD_BITS-1:3*COORD_BITS];

    assign diff_x = {end_x[COORD_BITS-1], end_x} - {start_x[COORD_BITS-1], start_x};
    assign diff_y = {end_y[COORD_BITS-1], end_y} - {start_y[COORD_BITS-1], start_y};
    assign abs_x  = diff_x[COORD_BITS] ? COORD_BITS'(-diff_x) : diff_x[COORD_BITS-1:0];
    assign abs_y  = diff_y[COORD_BITS] ? COORD_BITS'(-diff_y) : diff_y[COORD_BITS-1:0];

    assign load_flip     = abs_y > abs_x;
    assign load_major    = load_flip ? abs_y : abs_x;
    assign load_minor    = load_flip ? abs_x : abs_y;
    assign load_decision = $signed(DEC_BITS'({load_minor, 1'b0}))
                           - $signed(DEC_BITS'(load_major));

    // effective register values
    assign width_eff = (line_width_reg == '0) ? 8'd1 :
                       ((8'(line_width_reg) > 8'(MAX_WIDTH)) ? 8'(MAX_WIDTH) :
                        8'(line_width_reg));
    assign width_done = (8'(width_index_reg) + 8'd1) >= width_eff;
    assign dash_eff   = DASH_BITS'((dash_length_reg == '0) ? CNT_BITS'(1) : dash_length_reg);
    assign gap_eff    = (gap_length_reg == '0) ? CNT_BITS'(1) : gap_length_reg;
    assign dot_eff    = (dot_period_reg == '0) ? CNT_BITS'(1) : dot_period_reg;
    assign dot_inc    = (CNT_BITS+1)'(dot_counter_reg) + (CNT_BITS+1)'(1);

    // style pattern for the current pixel
    always_comb
    begin
        offset     = width_index_reg;
        plot       = 1'b1;
        step_done  = width_done;
        dash_mid   = dash_counter_reg;
        gap_mid    = gap_counter_reg;
        in_gap_mid = in_gap_reg;
        case (line_style_reg)
            STYLE_DOTTED:
            begin
                offset    = '0;
                plot      = (dot_counter_reg == '0);
                step_done = 1'b1;
            end
            STYLE_DASHED:
            begin
                if ((dash_counter_reg != dash_eff) && !in_gap_reg)
                begin
                    plot = 1'b1;
                end
                else
                begin
                    plot       = 1'b0;
                    in_gap_mid = 1'b1;
                    gap_mid    = gap_counter_reg + CNT_BITS'(1);
                    if (gap_mid == gap_eff)
                    begin
                        dash_mid   = '0;
                        gap_mid    = '0;
                        in_gap_mid = 1'b0;
                    end
                end
            end
            default:
            begin
                plot = 1'b1;
            end
        endcase
    end

    // pixel position with width offset across the minor axis
    assign pix_x = flip_reg ? (cur_x_reg + COORD_BITS'(offset)) : cur_x_reg;
    assign pix_y = flip_reg ? cur_y_reg : (cur_y_reg + COORD_BITS'(offset));

    // one Bresenham step
    assign x_stepped = neg_x_reg ? (cur_x_reg - COORD_BITS'(1)) : (cur_x_reg + COORD_BITS'(1));
    assign y_stepped = neg_y_reg ? (cur_y_reg - COORD_BITS'(1)) : (cur_y_reg + COORD_BITS'(1));
    assign two_minor = $signed(DEC_BITS'({minor_reg, 1'b0}));
    assign two_major = $signed(DEC_BITS'({major_reg, 1'b0}));

    // next state
    always_comb
    begin
        active_next       = active_reg;
        cur_x_next        = cur_x_reg;
        cur_y_next        = cur_y_reg;
        major_next        = major_reg;
        minor_next        = minor_reg;
        decision_next     = decision_reg;
        steps_left_next   = steps_left_reg;
        neg_x_next        = neg_x_reg;
        neg_y_next        = neg_y_reg;
        flip_next         = flip_reg;
        width_index_next  = width_index_reg;
        dot_counter_next  = dot_counter_reg;
        dash_counter_next = dash_counter_reg;
        in_gap_next       = in_gap_reg;
        gap_counter_next  = gap_counter_reg;

        out_valid_next = out_valid_reg && !m_axis_tready;
        out_x_next     = out_x_reg;
        out_y_next     = out_y_reg;
        out_plot_next  = out_plot_reg;
        out_last_next  = out_last_reg;
        out_idle_next  = out_idle_reg;

        if (in_accept)
        begin
            if (s_axis_tuser == OP_LOAD)
            begin
                // new line replaces any active one
                active_next       = 1'b1;
                cur_x_next        = start_x;
                cur_y_next        = start_y;
                major_next        = load_major;
                minor_next        = load_minor;
                decision_next     = load_decision;
                steps_left_next   = load_major;
                neg_x_next        = diff_x[COORD_BITS];
                neg_y_next        = diff_y[COORD_BITS];
                flip_next         = load_flip;
                width_index_next  = '0;
                dot_counter_next  = '0;
                dash_counter_next = '0;
                in_gap_next       = 1'b0;
                gap_counter_next  = '0;
            end
            else if (!active_reg)
            begin
                // idle word
                out_valid_next = 1'b1;
                out_x_next     = '0;
                out_y_next     = '0;
                out_plot_next  = 1'b0;
                out_last_next  = 1'b0;
                out_idle_next  = 1'b1;
            end
            else
            begin
                out_valid_next = 1'b1;
                out_x_next     = pix_x;
                out_y_next     = pix_y;
                out_plot_next  = plot;
                out_last_next  = step_done && (steps_left_reg == '0);
                out_idle_next  = 1'b0;

                dash_counter_next = dash_mid;
                gap_counter_next  = gap_mid;
                in_gap_next       = in_gap_mid;

                if (!step_done)
                begin
                    width_index_next = width_index_reg + WIDX_BITS'(1);
                end
                else
                begin
                    width_index_next  = '0;
                    dot_counter_next  = (dot_inc >= (CNT_BITS+1)'(dot_eff)) ? '0 :
                                        dot_inc[CNT_BITS-1:0];
                    dash_counter_next = dash_mid + DASH_BITS'(1);
                    if (steps_left_reg == '0)
                    begin
                        active_next = 1'b0;
                    end
                    else
                    begin
                        // minor axis moves only when the decision term is non-negative
                        if (decision_reg < 0)
                        begin
                            if (flip_reg)
                            begin
                                cur_y_next = y_stepped;
                            end
                            else
                            begin
                                cur_x_next = x_stepped;
                            end
                            decision_next = decision_reg + two_minor;
                        end
                        else
                        begin
                            cur_x_next    = x_stepped;
                            cur_y_next    = y_stepped;
                            decision_next = decision_reg + two_minor - two_major;
                        end
                        steps_left_next = steps_left_reg - COORD_BITS'(1);
                    end
                end
            end
        end
    end

    // state and output registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg       <= 1'b0;
            cur_x_reg        <= '0;
            cur_y_reg        <= '0;
            major_reg        <= '0;
            minor_reg        <= '0;
            decision_reg     <= '0;
            steps_left_reg   <= '0;
            neg_x_reg        <= 1'b0;
            neg_y_reg        <= 1'b0;
            flip_reg         <= 1'b0;
            width_index_reg  <= '0;
            dot_counter_reg  <= '0;
            dash_counter_reg <= '0;
            in_gap_reg       <= 1'b0;
            gap_counter_reg  <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            active_reg       <= active_next;
            cur_x_reg        <= cur_x_next;
            cur_y_reg        <= cur_y_next;
            major_reg        <= major_next;
            minor_reg        <= minor_next;
            decision_reg     <= decision_next;
            steps_left_reg   <= steps_left_next;
            neg_x_reg        <= neg_x_next;
            neg_y_reg        <= neg_y_next;
            flip_reg         <= flip_next;
            width_index_reg  <= width_index_next;
            dot_counter_reg  <= dot_counter_next;
            dash_counter_reg <= dash_counter_next;
            in_gap_reg       <= in_gap_next;
            gap_counter_reg  <= gap_counter_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    // output payload
    always_ff @(posedge clk)
    begin
        out_x_reg    <= out_x_next;
        out_y_reg    <= out_y_next;
        out_plot_reg <= out_plot_next;
        out_last_reg <= out_last_next;
        out_idle_reg <= out_idle_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = OUT_TDATA_W'({out_y_reg, out_x_reg});
    assign m_axis_tuser  = {out_idle_reg, out_plot_reg};
    assign m_axis_tlast  = out_last_reg;

endmodule

`default_nettype wire

// ----- hdl/stlr_checker.sv -----
// Port-level checker for the styled thick line rasterizer core, with the bind
// that attaches it. Depends on stlr_pkg and styled_thick_line_rasterizer_core.
`timescale 1ns / 1ps
`default_nettype none

module stlr_checker
    import stlr_pkg::*;
(
    input wire logic                   clk,
    input wire logic                   rst_n,
    input wire logic                   s_axis_tvalid,
    input wire logic                   s_axis_tready,
    input wire logic                   s_axis_tuser,
    input wire logic                   m_axis_tvalid,
    input wire logic                   m_axis_tready,
    input wire logic [OUT_TDATA_W-1:0] m_axis_tdata,
    input wire logic [1:0]             m_axis_tuser,
    input wire logic                   m_axis_tlast
);

    // a stalled word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
            && $stable(m_axis_tlast))
        else $error("output word changed while stalled");

    // idle words carry nothing else
    a_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[USER_IDLE] |->
            m_axis_tdata == '0 && !m_axis_tuser[USER_PLOT] && !m_axis_tlast)
        else $error("idle word with nonzero fields");

    // a load makes no output word
    a_load_silent: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tuser == OP_LOAD |=> !m_axis_tvalid)
        else $error("load produced an output word");

    // an advance makes a word on the next cycle
    a_advance_word: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tuser == OP_ADVANCE |=> m_axis_tvalid)
        else $error("advance produced no output word");

    // empty output register never blocks input
    a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty output");

endmodule

bind styled_thick_line_rasterizer_core stlr_checker u_stlr_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire
